FILE: hw/rtl/asar_pkg.sv
package asar_pkg;

    localparam int ACTION_COUNT = 8;
    localparam int REPEAT_CAP   = 4;
    localparam int IDX_W        = 3;
    localparam int VAL_W        = 9;
    localparam int EL_W         = 16;
    localparam int TIME_W       = 32;
    localparam int IV_W         = 16;
    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 3;

    localparam logic [VAL_W-1:0]  VAL_FULL = VAL_W'(256);
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_IV = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IV = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUPP   = 3'd4;

    // register reset values
    localparam logic [IV_W-1:0] RST_MIN_IV = 16'd50;
    localparam logic [IV_W-1:0] RST_MAX_IV = 16'd300;
    localparam logic [IV_W-1:0] RST_RAMP   = 16'd1000;

    // item kinds
    localparam logic MODE_SET  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [IDX_W-1:0]  idx;
        logic [VAL_W-1:0]  val;
        logic [EL_W-1:0]   elapsed;
    } t_item;

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] num;
        logic [IV_W-1:0]   den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [TIME_W-1:0] quot;
    } t_div_rsp;

    // an interval of zero counts as one ms
    function automatic logic [IV_W-1:0] fix_iv(input logic [IV_W-1:0] v);
        fix_iv = (v == '0) ? IV_W'(1) : v;
    endfunction

endpackage

FILE: hw/rtl/asar_front.sv
module asar_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  asar_pkg::t_item      i_item,
    output logic                 o_avail,
    output asar_pkg::t_item      o_item,
    input  logic                 i_pop
);

    asar_pkg::t_item r_mem [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    asar_pkg::t_item w_item;
    logic            w_push, w_pop;

    // clamp the value on the way in
    always_comb begin
        w_item = i_item;
        if (i_item.val > asar_pkg::VAL_FULL) begin
            w_item.val = asar_pkg::VAL_FULL;
        end
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && o_avail;

    // two-entry queue toward the back end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_item;
        end
    end

endmodule

FILE: hw/rtl/asar_div.sv
module asar_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  asar_pkg::t_div_req  i_req,
    output asar_pkg::t_div_rsp  o_rsp
);

    logic [asar_pkg::TIME_W-1:0] r_q;
    logic [asar_pkg::IV_W-1:0]   r_rem, r_den;
    logic [4:0]                  r_cnt;
    logic                        r_busy, r_done;
    logic [asar_pkg::IV_W:0]     w_trial;
    logic                        w_ge;

    assign w_trial = {r_rem, r_q[asar_pkg::TIME_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= w_ge ? asar_pkg::IV_W'(w_trial - {1'b0, r_den})
                          : w_trial[asar_pkg::IV_W-1:0];
            r_q   <= {r_q[asar_pkg::TIME_W-2:0], w_ge};
        end
    end

endmodule

FILE: hw/rtl/asar_back.sv
module asar_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [asar_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [asar_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_avail,
    input  asar_pkg::t_item               i_item,
    output logic                          o_pop,
    output asar_pkg::t_div_req            o_div_req,
    input  asar_pkg::t_div_rsp            i_div_rsp,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [asar_pkg::IDX_W-1:0]    o_action,
    output logic [asar_pkg::VAL_W-1:0]    o_value,
    output logic                          o_repeat,
    output logic                          o_last
);

    localparam int TW = asar_pkg::TIME_W;
    localparam int VW = asar_pkg::VAL_W;
    localparam int IW = asar_pkg::IV_W;
    localparam int XW = asar_pkg::IDX_W;
    localparam int AC = asar_pkg::ACTION_COUNT;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_CHG   = 13'b0000000000010,
        S_UPD   = 13'b0000000000100,
        S_EVAL  = 13'b0000000001000,
        S_MUL   = 13'b0000000010000,
        S_DS1   = 13'b0000000100000,
        S_DW1   = 13'b0000001000000,
        S_DS2   = 13'b0000010000000,
        S_DW2   = 13'b0000100000000,
        S_MULK  = 13'b0001000000000,
        S_ADV   = 13'b0010000000000,
        S_REP   = 13'b0100000000000,
        S_FLUSH = 13'b1000000000000
    } t_state;

    t_state r_st, n_st;

    // configuration
    logic [asar_pkg::CFG_W-1:0] r_thr;
    logic [IW-1:0]              r_min, r_max, r_ramp;
    logic                       r_sup;

    // per-action state
    logic [VW-1:0] r_cur [AC], n_cur [AC];
    logic [VW-1:0] r_prev[AC], n_prev[AC];
    logic [TW-1:0] r_dur [AC], n_dur [AC];
    logic [TW-1:0] r_nxt [AC], n_nxt [AC];

    // work registers
    logic [XW-1:0]      r_a, n_a;
    logic [15:0]        r_el, n_el;
    logic [IW-1:0]      r_iv, n_iv;
    logic [TW+IW-1:0]   r_prod, n_prod;
    logic [TW-1:0]      r_quot, n_quot;
    logic [2:0]         r_cnt, n_cnt;

    // held event and output register
    logic               r_pv, n_pv;
    logic [XW-1:0]      r_pact, n_pact;
    logic [VW-1:0]      r_pval, n_pval;
    logic               r_prep, n_prep;
    logic               r_ov, n_ov;
    logic [XW-1:0]      r_oact, n_oact;
    logic [VW-1:0]      r_oval, n_oval;
    logic               r_orep, n_orep;
    logic               r_olast, n_olast;

    logic [VW-1:0]  w_cur, w_prev;
    logic [TW-1:0]  w_dur, w_nxt;
    logic [7:0]     w_thr;
    logic [IW-1:0]  w_span, w_v;
    logic [TW:0]    w_sum;
    logic [TW+IW+1:0] w_adv;
    logic           w_free, w_want, w_erep, w_eok, w_cond, w_last_a;

    assign w_cur    = r_cur[r_a];
    assign w_prev   = r_prev[r_a];
    assign w_dur    = r_dur[r_a];
    assign w_nxt    = r_nxt[r_a];
    assign w_thr    = r_thr[{r_a, 3'b000} +: 8];
    assign w_span   = r_max - r_min;
    assign w_free   = !r_ov || i_ready;
    assign w_eok    = !r_pv || w_free;
    assign w_last_a = (r_a == XW'(AC - 1));
    assign w_sum    = {1'b0, w_dur} + (TW + 1)'(r_el);
    assign w_adv    = (TW + IW + 2)'(r_prod) + (TW + IW + 2)'(r_iv) + (TW + IW + 2)'(w_nxt);
    assign w_v      = (i_div_rsp.quot >= TW'(w_span)) ? r_min
                                                      : r_max - i_div_rsp.quot[IW-1:0];

    // repeat falls due for the current action
    assign w_cond = (w_thr != 8'd0) && (w_cur > {1'b0, w_thr}) && (w_dur != '0)
                 && !((w_dur >= TW'(r_el)) && ((w_dur - TW'(r_el)) >= w_nxt))
                 && (w_dur >= w_nxt);

    assign o_valid  = r_ov;
    assign o_action = r_oact;
    assign o_value  = r_oval;
    assign o_repeat = r_orep;
    assign o_last   = r_olast;

    // sequencer
    always_comb begin
        n_st    = r_st;
        n_cur   = r_cur;
        n_prev  = r_prev;
        n_dur   = r_dur;
        n_nxt   = r_nxt;
        n_a     = r_a;
        n_el    = r_el;
        n_iv    = r_iv;
        n_prod  = r_prod;
        n_quot  = r_quot;
        n_cnt   = r_cnt;
        n_pv    = r_pv;
        n_pact  = r_pact;
        n_pval  = r_pval;
        n_prep  = r_prep;
        n_ov    = r_ov && !i_ready;
        n_oact  = r_oact;
        n_oval  = r_oval;
        n_orep  = r_orep;
        n_olast = r_olast;
        w_want  = 1'b0;
        w_erep  = 1'b0;
        o_pop   = 1'b0;
        o_div_req.start = 1'b0;
        o_div_req.num   = w_dur - w_nxt;
        o_div_req.den   = r_iv;

        case (r_st)
            S_IDLE: begin
                if (i_avail) begin
                    o_pop = 1'b1;
                    if (i_item.mode == asar_pkg::MODE_SET) begin
                        if ({1'b0, i_item.idx} < (XW + 1)'(AC)) begin
                            n_cur[i_item.idx] = i_item.val;
                        end
                    end else begin
                        n_el = i_item.elapsed;
                        n_a  = '0;
                        n_st = S_CHG;
                    end
                end
            end
            S_CHG: begin
                w_want = (w_cur != w_prev) && !r_sup;
                if (!w_want || w_eok) begin
                    if (w_last_a) begin
                        n_a  = '0;
                        n_st = S_UPD;
                    end else begin
                        n_a = r_a + XW'(1);
                    end
                end
            end
            S_UPD: begin
                if ((w_cur != '0) != (w_prev != '0)) begin
                    n_dur[r_a] = '0;
                    n_nxt[r_a] = TW'(r_max);
                end else begin
                    n_dur[r_a] = w_sum[TW] ? asar_pkg::TIME_MAX : w_sum[TW-1:0];
                end
                n_st = S_EVAL;
            end
            S_EVAL: begin
                if (!w_cond) begin
                    n_st = S_REP;
                    n_cnt = '0;
                end else if (r_min >= r_max) begin
                    n_iv = asar_pkg::fix_iv(r_max);
                    n_st = S_DS2;
                end else if ((r_ramp == '0) || (w_dur >= TW'(r_ramp))) begin
                    n_iv = asar_pkg::fix_iv(r_min);
                    n_st = S_DS2;
                end else begin
                    n_st = S_MUL;
                end
            end
            S_MUL: begin
                n_prod = (TW + IW)'(TW'(w_dur[IW-1:0]) * TW'(w_span));
                n_st   = S_DS1;
            end
            S_DS1: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = r_prod[TW-1:0];
                o_div_req.den   = r_ramp;
                n_st = S_DW1;
            end
            S_DW1: begin
                if (i_div_rsp.done) begin
                    n_iv = asar_pkg::fix_iv(w_v);
                    n_st = S_DS2;
                end
            end
            S_DS2: begin
                o_div_req.start = 1'b1;
                n_st = S_DW2;
            end
            S_DW2: begin
                if (i_div_rsp.done) begin
                    n_quot = i_div_rsp.quot;
                    n_st   = S_MULK;
                end
            end
            S_MULK: begin
                n_prod = r_quot * r_iv;
                n_st   = S_ADV;
            end
            S_ADV: begin
                n_nxt[r_a] = (w_adv > (TW + IW + 2)'(asar_pkg::TIME_MAX))
                           ? asar_pkg::TIME_MAX : w_adv[TW-1:0];
                n_cnt = (r_quot >= TW'(asar_pkg::REPEAT_CAP)) ? 3'(asar_pkg::REPEAT_CAP)
                                                              : r_quot[2:0] + 3'd1;
                n_st  = S_REP;
            end
            S_REP: begin
                if ((r_cnt == '0) || r_sup) begin
                    if (w_last_a) begin
                        n_prev = r_cur;
                        n_st   = S_FLUSH;
                    end else begin
                        n_a  = r_a + XW'(1);
                        n_st = S_UPD;
                    end
                end else begin
                    w_want = 1'b1;
                    w_erep = 1'b1;
                    if (w_eok) begin
                        n_cnt = r_cnt - 3'd1;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pv) begin
                    n_st = S_IDLE;
                end else if (w_free) begin
                    n_ov    = 1'b1;
                    n_oact  = r_pact;
                    n_oval  = r_pval;
                    n_orep  = r_prep;
                    n_olast = 1'b1;
                    n_pv    = 1'b0;
                    n_st    = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase

        // an event goes to the held slot; the one held before moves out
        if (w_want && w_eok) begin
            if (r_pv) begin
                n_ov    = 1'b1;
                n_oact  = r_pact;
                n_oval  = r_pval;
                n_orep  = r_prep;
                n_olast = 1'b0;
            end
            n_pv   = 1'b1;
            n_pact = r_a;
            n_pval = w_cur;
            n_prep = w_erep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_pv   <= 1'b0;
            r_ov   <= 1'b0;
            r_a    <= '0;
            r_cnt  <= '0;
            r_thr  <= '0;
            r_min  <= asar_pkg::RST_MIN_IV;
            r_max  <= asar_pkg::RST_MAX_IV;
            r_ramp <= asar_pkg::RST_RAMP;
            r_sup  <= 1'b0;
            for (int i = 0; i < AC; i++) begin
                r_cur[i]  <= '0;
                r_prev[i] <= '0;
                r_dur[i]  <= '0;
                r_nxt[i]  <= '0;
            end
        end else begin
            r_st   <= n_st;
            r_pv   <= n_pv;
            r_ov   <= n_ov;
            r_a    <= n_a;
            r_cnt  <= n_cnt;
            r_cur  <= n_cur;
            r_prev <= n_prev;
            r_dur  <= n_dur;
            r_nxt  <= n_nxt;
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    asar_pkg::CFG_THRESH: r_thr  <= i_cfg_data;
                    asar_pkg::CFG_MIN_IV: r_min  <= i_cfg_data[IW-1:0];
                    asar_pkg::CFG_MAX_IV: r_max  <= i_cfg_data[IW-1:0];
                    asar_pkg::CFG_RAMP:   r_ramp <= i_cfg_data[IW-1:0];
                    asar_pkg::CFG_SUPP:   r_sup  <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_el    <= n_el;
        r_iv    <= n_iv;
        r_prod  <= n_prod;
        r_quot  <= n_quot;
        r_pact  <= n_pact;
        r_pval  <= n_pval;
        r_prep  <= n_prep;
        r_oact  <= n_oact;
        r_oval  <= n_oval;
        r_orep  <= n_orep;
        r_olast <= n_olast;
    end

endmodule

FILE: hw/rtl/action_state_auto_repeat.sv
// Key auto-repeat with a ramping interval for eight actions.
// Input stream (s_axis): tuser = mode (0 set value, 1 frame tick);
//   tdata = action_index[2:0], action_value[11:3], elapsed_ms[27:12].
// Output stream (m_axis): tdata = event_action[2:0], event_value[11:3];
//   tuser = is_repeat; tlast marks the final event of a tick.
// Config port: i_cfg_we with i_cfg_idx 0 thresholds, 1 min interval,
//   2 max interval, 3 ramp time, 4 suppress; write only while idle.
// A two-entry queue decouples intake from the sequencer, so items are
// taken while a tick is being worked off. Items are handled one at a time.
// A set item is handled in the idle state. For each action with repeats due,
// the shared divider runs once, or twice when the interval ramps. The last
// event of a tick is held back until the tick ends so it can carry tlast.
// A stalled receiver stalls the sequencer; the queue keeps taking input
// until full. Reset clears the control and per-action state and restores
// the configuration defaults.
module action_state_auto_repeat (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // action_index, action_value, elapsed_ms
    input  logic        i_s_axis_tuser,   // mode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // event_action, event_value
    output logic        o_m_axis_tuser,   // is_repeat
    output logic        o_m_axis_tlast
);

    asar_pkg::t_item    w_in_item, w_q_item;
    asar_pkg::t_div_req w_div_req;
    asar_pkg::t_div_rsp w_div_rsp;
    logic               w_avail, w_pop;
    logic [asar_pkg::IDX_W-1:0] w_act;
    logic [asar_pkg::VAL_W-1:0] w_val;

    // unpack the input transfer
    assign w_in_item.mode    = i_s_axis_tuser;
    assign w_in_item.idx     = i_s_axis_tdata[2:0];
    assign w_in_item.val     = i_s_axis_tdata[11:3];
    assign w_in_item.elapsed = i_s_axis_tdata[27:12];

    asar_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (w_in_item),
        .o_avail (w_avail),
        .o_item  (w_q_item),
        .i_pop   (w_pop)
    );

    asar_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    asar_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_avail    (w_avail),
        .i_item     (w_q_item),
        .o_pop      (w_pop),
        .o_div_req  (w_div_req),
        .i_div_rsp  (w_div_rsp),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_action   (w_act),
        .o_value    (w_val),
        .o_repeat   (o_m_axis_tuser),
        .o_last     (o_m_axis_tlast)
    );

    // pack the output transfer
    assign o_m_axis_tdata = {4'b0000, w_val, w_act};

endmodule

FILE: hw/rtl/asar_checker.sv
module asar_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    // nothing comes out right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // queue is empty after reset, so input is taken
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready)
        else $error("input not ready after reset");

    // event values never exceed full scale and padding stays zero
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[11:3] <= 9'd256)
                            && (o_m_axis_tdata[15:12] == 4'd0))
        else $error("event value out of range");

    // a stalled transfer holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled output changed");

endmodule

bind action_state_auto_repeat asar_checker u_asar_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
